// ----- hdl/ssr_pkg.sv -----
// shared types and constants for the stereo reverb
package ssr_pkg;

  // pipeline depth from accept to output register
  localparam int unsigned NST = 7;

  // comb feedback 0.78 in Q1.15
  localparam logic signed [15:0] COMB_FB = 16'sd25559;

  localparam int unsigned NCOMB = 4;
  localparam int unsigned NAP   = 2;
  localparam int unsigned NLINE = NCOMB + NAP;

  localparam logic [10:0] COMB_BASE [NCOMB] = '{11'd1116, 11'd1188, 11'd1277, 11'd1356};
  localparam logic [10:0] AP_BASE   [NAP]   = '{11'd556, 11'd441};
  localparam logic [10:0] SPREAD            = 11'd23;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_DRY   = 2'd1,
    REG_WET   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic           adv;
    logic           clr;
    logic [NST:1]   vld;
  } ctl_t;

endpackage

// ----- hdl/ssr_dline.sv -----
// one delay line memory, registered read
module ssr_dline #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned W     = 28
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ssr_ctrl.sv -----
// config registers, delay lengths, circular positions, memory clear and stage valids
module ssr_ctrl #(
  parameter int unsigned MAX_DELAY = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         out_ready_i,
  output logic                         in_ready_o,
  output ssr_pkg::ctl_t                ctl_o,
  output logic [$clog2(MAX_DELAY)-1:0] clr_addr_o,
  output logic [$clog2(MAX_DELAY)-1:0] addr_l_o [ssr_pkg::NLINE],
  output logic [$clog2(MAX_DELAY)-1:0] addr_r_o [ssr_pkg::NLINE],
  output logic [14:0]                  dry_o,
  output logic [14:0]                  wet_o
);

  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam int unsigned LW = $clog2(MAX_DELAY + 1);
  localparam int unsigned NP = 2 * ssr_pkg::NLINE;

  logic [15:0]        scale_q;
  logic [14:0]        dry_q, wet_q;
  logic               upd_q;
  logic               clr_q;
  logic [AW-1:0]      cnt_q;
  logic [ssr_pkg::NST:1] vld_q;
  logic [LW-1:0]      len_q [NP];
  logic [LW-1:0]      len_d [NP];
  logic [AW-1:0]      pos_q [NP];
  logic [AW-1:0]      pos_d [NP];
  logic [AW-1:0]      addr  [NP];
  logic               adv, take;
  logic               short_line;

  // a line shorter than the write-back distance holds a request off until the one before has written all lines
  always_comb begin
    short_line = 1'b0;
    for (int k = 0; k < NP; k++) begin
      if (len_q[k] < LW'(5)) begin
        short_line = 1'b1;
      end
    end
  end

  assign adv        = ~vld_q[ssr_pkg::NST] | out_ready_i;
  assign in_ready_o = adv & ~clr_q & ~upd_q & ~(short_line & (|vld_q[4:1]));
  assign take       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 16'd16384;
      dry_q   <= 15'd32767;
      wet_q   <= 15'd0;
      upd_q   <= 1'b0;
    end else begin
      upd_q <= cfg_we_i && (cfg_idx_i == ssr_pkg::REG_SCALE);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ssr_pkg::REG_SCALE: scale_q <= cfg_data_i;
          ssr_pkg::REG_DRY:   dry_q   <= cfg_data_i[14:0];
          ssr_pkg::REG_WET:   wet_q   <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // memory clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else if (clr_q) begin
      cnt_q <= cnt_q + AW'(1);
      if (cnt_q == AW'(MAX_DELAY - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ssr_pkg::NST-1:1], take};
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_pos
    localparam int unsigned I = k % ssr_pkg::NLINE;
    localparam logic [10:0] BASE = ((I < ssr_pkg::NCOMB) ? ssr_pkg::COMB_BASE[I % ssr_pkg::NCOMB]
                                    : ssr_pkg::AP_BASE[(I + ssr_pkg::NAP - ssr_pkg::NCOMB)
                                                       % ssr_pkg::NAP])
                                   + ((k >= ssr_pkg::NLINE) ? ssr_pkg::SPREAD : 11'd0);
    logic [31:0] q;
    logic [LW-1:0] nx;

    // round(base * scale / 2^14), clamped to 1..MAX_DELAY
    always_comb begin
      q = (32'(BASE) * 32'(scale_q) + 32'd8192) >> 14;
      if (q < 32'd1) begin
        len_d[k] = LW'(1);
      end else if (q > 32'(MAX_DELAY)) begin
        len_d[k] = LW'(MAX_DELAY);
      end else begin
        len_d[k] = q[LW-1:0];
      end
    end

    // a position left past a shortened line restarts at zero
    always_comb begin
      addr[k]  = (LW'(pos_q[k]) >= len_q[k]) ? '0 : pos_q[k];
      nx       = LW'(addr[k]) + LW'(1);
      pos_d[k] = (nx >= len_q[k]) ? '0 : nx[AW-1:0];
    end

    always_ff @(posedge clk_i) begin
      len_q[k] <= len_d[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q[k] <= '0;
      end else if (take) begin
        pos_q[k] <= pos_d[k];
      end
    end
  end

  for (genvar i = 0; i < ssr_pkg::NLINE; i++) begin : g_addr
    assign addr_l_o[i] = addr[i];
    assign addr_r_o[i] = addr[i + ssr_pkg::NLINE];
  end

  assign ctl_o.adv  = adv;
  assign ctl_o.clr  = clr_q;
  assign ctl_o.vld  = vld_q;
  assign clr_addr_o = cnt_q;
  assign dry_o      = dry_q;
  assign wet_o      = wet_q;

endmodule

// ----- hdl/ssr_lane.sv -----
// one channel: four combs, two allpasses and the dry/wet mix, pipelined
module ssr_lane #(
  parameter int unsigned MAX_DELAY    = 4096,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                                clk_i,
  input  ssr_pkg::ctl_t                       ctl_i,
  input  logic [$clog2(MAX_DELAY)-1:0]        clr_addr_i,
  input  logic [$clog2(MAX_DELAY)-1:0]        addr_i [ssr_pkg::NLINE],
  input  logic signed [SAMPLE_WIDTH-1:0]      x_i,
  input  logic [14:0]                         dry_i,
  input  logic [14:0]                         wet_i,
  output logic signed [SAMPLE_WIDTH-1:0]      y_o
);

  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned AC = SW + 4;
  localparam int unsigned PW = AC + 16;
  localparam int unsigned MW = AC + 17;

  function automatic logic signed [AC-1:0] sat_ac(input logic signed [AC+2:0] v);
    if (&v[AC+2:AC-1] || ~|v[AC+2:AC-1]) begin
      return v[AC-1:0];
    end
    return v[AC+2] ? {1'b1, {(AC-1){1'b0}}} : {1'b0, {(AC-1){1'b1}}};
  endfunction

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [SW+5:0] v);
    if (&v[SW+5:SW-1] || ~|v[SW+5:SW-1]) begin
      return v[SW-1:0];
    end
    return v[SW+5] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  endfunction

  // round half up of v / 2
  function automatic logic signed [AC-1:0] half(input logic signed [AC-1:0] v);
    logic signed [AC:0] t;
    t = {v[AC-1], v} + (AC+1)'(1);
    return t[AC:1];
  endfunction

  logic [AC-1:0]         crd [ssr_pkg::NCOMB];
  logic [AC-1:0]         ard [ssr_pkg::NAP];
  logic signed [AC-1:0]  ycomb [ssr_pkg::NCOMB];
  logic [AW-1:0]         cad1_q [ssr_pkg::NCOMB];
  logic [AW-1:0]         cad2_q [ssr_pkg::NCOMB];
  logic [AW-1:0]         aad1_q [ssr_pkg::NAP];
  logic [AW-1:0]         aad2_q [ssr_pkg::NAP];
  logic [AW-1:0]         aad3_q [ssr_pkg::NAP];
  logic [AW-1:0]         aad4_q;
  logic signed [PW-1:0]  cprod2_q [ssr_pkg::NCOMB];
  logic signed [SW-1:0]  x1_q, x2_q, x3_q, x4_q, x5_q;
  logic signed [AC-1:0]  a0_2_q, a0_3_q, a1_2_q, a1_3_q, a1_4_q;
  logic signed [AC+1:0]  csum3_q;
  logic signed [AC+1:0]  csum_d;
  logic signed [AC-1:0]  y0_4_q, y1_5_q;
  logic signed [AC-1:0]  s3, y0, w0, y1, w1;
  logic signed [AC+1:0]  sr;
  logic signed [SW+15:0] pd6_q;
  logic signed [PW-1:0]  pw6_q;
  logic signed [MW-1:0]  mix;
  logic signed [SW-1:0]  out7_q;

  for (genvar i = 0; i < ssr_pkg::NCOMB; i++) begin : g_comb
    logic signed [PW-1:0] r;
    logic signed [AC+2:0] t;

    always_comb begin
      r        = cprod2_q[i] + PW'(16384);
      t        = (AC+3)'(x2_q) + (AC+3)'($signed(r[PW-1:15]));
      ycomb[i] = sat_ac(t);
    end

    ssr_dline #(.DEPTH(MAX_DELAY), .W(AC)) u_line (
      .clk_i   (clk_i),
      .re_i    (ctl_i.adv),
      .raddr_i (addr_i[i]),
      .rdata_o (crd[i]),
      .we_i    (ctl_i.clr | (ctl_i.adv & ctl_i.vld[2])),
      .waddr_i (ctl_i.clr ? clr_addr_i : cad2_q[i]),
      .wdata_i (ctl_i.clr ? '0 : ycomb[i])
    );
  end

  always_comb begin
    csum_d = '0;
    for (int i = 0; i < ssr_pkg::NCOMB; i++) begin
      csum_d = csum_d + (AC+2)'(ycomb[i]);
    end
  end

  // stage 3 to 4: comb average and first allpass
  always_comb begin
    sr = csum3_q + (AC+2)'(2);
    s3 = sr[AC+1:2];
    y0 = sat_ac((AC+3)'(a0_3_q) - (AC+3)'(half(s3)));
    w0 = sat_ac((AC+3)'(s3) + (AC+3)'(half(y0)));
  end

  // stage 4 to 5: second allpass
  always_comb begin
    y1 = sat_ac((AC+3)'(a1_4_q) - (AC+3)'(half(y0_4_q)));
    w1 = sat_ac((AC+3)'(y0_4_q) + (AC+3)'(half(y1)));
  end

  ssr_dline #(.DEPTH(MAX_DELAY), .W(AC)) u_ap0 (
    .clk_i   (clk_i),
    .re_i    (ctl_i.adv),
    .raddr_i (addr_i[ssr_pkg::NCOMB]),
    .rdata_o (ard[0]),
    .we_i    (ctl_i.clr | (ctl_i.adv & ctl_i.vld[3])),
    .waddr_i (ctl_i.clr ? clr_addr_i : aad3_q[0]),
    .wdata_i (ctl_i.clr ? '0 : w0)
  );

  ssr_dline #(.DEPTH(MAX_DELAY), .W(AC)) u_ap1 (
    .clk_i   (clk_i),
    .re_i    (ctl_i.adv),
    .raddr_i (addr_i[ssr_pkg::NCOMB+1]),
    .rdata_o (ard[1]),
    .we_i    (ctl_i.clr | (ctl_i.adv & ctl_i.vld[4])),
    .waddr_i (ctl_i.clr ? clr_addr_i : aad4_q),
    .wdata_i (ctl_i.clr ? '0 : w1)
  );

  always_comb begin
    mix = MW'(pd6_q) + MW'(pw6_q) + MW'(16384);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      x1_q <= x_i;
      for (int i = 0; i < ssr_pkg::NCOMB; i++) begin
        cad1_q[i]   <= addr_i[i];
        cad2_q[i]   <= cad1_q[i];
        cprod2_q[i] <= $signed(crd[i]) * ssr_pkg::COMB_FB;
      end
      for (int j = 0; j < ssr_pkg::NAP; j++) begin
        aad1_q[j] <= addr_i[ssr_pkg::NCOMB + j];
        aad2_q[j] <= aad1_q[j];
        aad3_q[j] <= aad2_q[j];
      end
      aad4_q  <= aad3_q[1];
      x2_q    <= x1_q;
      a0_2_q  <= $signed(ard[0]);
      a1_2_q  <= $signed(ard[1]);
      csum3_q <= csum_d;
      x3_q    <= x2_q;
      a0_3_q  <= a0_2_q;
      a1_3_q  <= a1_2_q;
      y0_4_q  <= y0;
      x4_q    <= x3_q;
      a1_4_q  <= a1_3_q;
      y1_5_q  <= y1;
      x5_q    <= x4_q;
      pd6_q   <= x5_q * $signed({1'b0, dry_i});
      pw6_q   <= y1_5_q * $signed({1'b0, wet_i});
      out7_q  <= sat_sw(mix[MW-1:15]);
    end
  end

  assign y_o = out7_q;

endmodule

// ----- hdl/schroeder_stereo_reverb.sv -----
// Stereo Schroeder reverb: four feedback combs and two allpasses per channel, then a
// dry/wet mix saturated to the sample width. One stereo pair is taken every cycle unless
// the output stalls or a hold-off below applies; the work is a seven-stage pipeline
// around one delay memory per comb and allpass line, each read once and written once per
// sample. After reset the block sweeps all delay memories to zero, one address a cycle,
// and takes no samples meanwhile. A write to delay_scale holds off requests while the
// line lengths are recomputed. A delay_scale so small that some line is shorter than five
// samples holds each request off until the one before it has written all its lines. The
// user must write configuration only while idle; the block itself does not enforce it.
module schroeder_stereo_reverb #(
  parameter int unsigned MAX_DELAY    = 4096,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_o
);

  localparam int unsigned AW = $clog2(MAX_DELAY);

  ssr_pkg::ctl_t ctl;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr_l [ssr_pkg::NLINE];
  logic [AW-1:0] addr_r [ssr_pkg::NLINE];
  logic [14:0]   dry, wet;

  ssr_ctrl #(.MAX_DELAY(MAX_DELAY)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctl_o       (ctl),
    .clr_addr_o  (clr_addr),
    .addr_l_o    (addr_l),
    .addr_r_o    (addr_r),
    .dry_o       (dry),
    .wet_o       (wet)
  );

  ssr_lane #(.MAX_DELAY(MAX_DELAY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_left (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .clr_addr_i (clr_addr),
    .addr_i     (addr_l),
    .x_i        (in_left_i),
    .dry_i      (dry),
    .wet_i      (wet),
    .y_o        (out_left_o)
  );

  ssr_lane #(.MAX_DELAY(MAX_DELAY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_right (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .clr_addr_i (clr_addr),
    .addr_i     (addr_r),
    .x_i        (in_right_i),
    .dry_i      (dry),
    .wet_i      (wet),
    .y_o        (out_right_o)
  );

  assign out_valid_o = ctl.vld[ssr_pkg::NST];

endmodule
